/* rtl/ocvm_pkg.sv */
// ocvm_pkg: constants, types and helpers for the orbit camera view matrix
// depends on nothing
`default_nettype none
package ocvm_pkg;
    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int MAX_STAGES         = 24;
    localparam int FULL_TURN          = 23040;
    localparam int QUARTER_TURN       = 5760;
    localparam int HALF_TURN          = 11520;
    localparam int UNIT_TO_RAD        = 292818;
    localparam int CORDIC_START       = 652032874;

    typedef logic signed [33:0] q30_t;

    typedef logic [1:0] row_t;
    localparam row_t ROW_RIGHT = 2'd0;
    localparam row_t ROW_UP    = 2'd1;
    localparam row_t ROW_FWD   = 2'd2;
    localparam row_t ROW_HOMOG = 2'd3;

    function automatic q30_t atan_q30(input int i);
        unique case (i)
            0: atan_q30 = 34'sd843314856;
            1: atan_q30 = 34'sd497837829;
            2: atan_q30 = 34'sd263043836;
            3: atan_q30 = 34'sd133525158;
            4: atan_q30 = 34'sd67021686;
            5: atan_q30 = 34'sd33543515;
            6: atan_q30 = 34'sd16775850;
            7: atan_q30 = 34'sd8388437;
            8: atan_q30 = 34'sd4194282;
            9: atan_q30 = 34'sd2097149;
            10: atan_q30 = 34'sd1048575;
            11: atan_q30 = 34'sd524287;
            12: atan_q30 = 34'sd262143;
            13: atan_q30 = 34'sd131071;
            14: atan_q30 = 34'sd65535;
            15: atan_q30 = 34'sd32767;
            16: atan_q30 = 34'sd16383;
            17: atan_q30 = 34'sd8191;
            18: atan_q30 = 34'sd4095;
            19: atan_q30 = 34'sd2047;
            20: atan_q30 = 34'sd1023;
            21: atan_q30 = 34'sd511;
            22: atan_q30 = 34'sd255;
            default: atan_q30 = 34'sd127;
        endcase
    endfunction
endpackage
`default_nettype wire

/* rtl/orbit_camera_view_matrix.sv */
// orbit_camera_view_matrix: pipelined look-at view matrix for an orbit camera
// depends on ocvm_pkg
`default_nettype none
// A camera word (azimuth, polar angle, distance) goes through an angle reduction
// stage, one CORDIC rotation stage per register (two angles side by side), a
// sine/cosine folding stage, a product stage and a coefficient rounding stage.
// The row words come from a row holder that takes each word from the rounding
// stage. Each camera word leaves as four row words on the output, one per cycle
// while the output is not stalled, so the single-row output port sets the
// sustained rate. The input is stalled only while the end stage holds a word
// that the row holder cannot take yet; the holder takes the next word in the
// cycle its fourth row leaves, so rows of consecutive words follow with no gap.
// A stall on the output holds everything without loss.
module orbit_camera_view_matrix #(
    parameter int CORDIC_STAGES  = ocvm_pkg::CORDIC_STAGES_DEF,
    parameter int COEF_FRAC_BITS = ocvm_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  signed [15:0] azimuth_angle,
    input  wire  signed [15:0] polar_angle,
    input  wire         [15:0] view_distance,
    output logic               out_valid,
    input  wire                out_stall,
    output logic        [1:0]  row_index,
    output logic signed [15:0] coef_x,
    output logic signed [15:0] coef_y,
    output logic signed [15:0] coef_z,
    output logic signed [16:0] offset,
    output logic               degenerate,
    output logic               last_row
);
    localparam int NS = CORDIC_STAGES;
    localparam int SH = 30 - COEF_FRAC_BITS;

    typedef logic signed [33:0] q_t;
    typedef struct packed {
        q_t x; q_t y; q_t z;
        logic neg; logic exact;
        q_t ex_x; q_t ex_y;
    } ang_t;

    // pipeline advance: whole pipe moves when the end stage is empty or the row holder takes its word
    logic hold_full_reg, hold_full_next;
    logic [1:0] row_reg, row_next;
    logic adv;
    logic [NS+3:0] v_reg;
    logic end_take;
    assign end_take = v_reg[NS+3] && (!hold_full_reg ||
                      (!out_stall && row_reg == ocvm_pkg::ROW_HOMOG));
    assign adv = !v_reg[NS+3] || end_take;
    assign in_stall = !adv;

    // angle reduction
    function automatic ang_t reduce(input logic signed [15:0] raw);
        ang_t r;
        logic signed [16:0] a;
        // bring the angle into one turn without a divider
        a = 17'(raw);
        if (a < 0) a = a + 17'sd23040;
        if (a < 0) a = a + 17'sd23040;
        if (a >= 17'sd23040) a = a - 17'sd23040;
        r.neg = 1'b0;
        if (a > 17'sd17280) a = a - 17'sd23040;
        else if (a > 17'sd5760) begin a = a - 17'sd11520; r.neg = 1'b1; end
        r.exact = (a == 0) || (a == 17'sd5760) || (a == -17'sd5760);
        r.ex_x = (a == 0) ? 34'sd1073741824 : 34'sd0;
        r.ex_y = (a == 17'sd5760) ? 34'sd1073741824 :
                 (a == -17'sd5760) ? -34'sd1073741824 : 34'sd0;
        r.x = 34'(ocvm_pkg::CORDIC_START);
        r.y = '0;
        r.z = 34'(a) * 34'(ocvm_pkg::UNIT_TO_RAD);
        return r;
    endfunction

    ang_t t_reg [0:NS];
    ang_t p_reg [0:NS];
    logic [15:0] d_reg [0:NS+3];

    function automatic ang_t rot(input ang_t a, input int i);
        ang_t r;
        r = a;
        if (a.z >= 0) begin
            r.x = a.x - (a.y >>> i); r.y = a.y + (a.x >>> i);
            r.z = a.z - ocvm_pkg::atan_q30(i);
        end else begin
            r.x = a.x + (a.y >>> i); r.y = a.y - (a.x >>> i);
            r.z = a.z + ocvm_pkg::atan_q30(i);
        end
        return r;
    endfunction

    function automatic q_t clampq(input q_t v);
        if (v > 34'sd1073741824) return 34'sd1073741824;
        if (v < -34'sd1073741824) return -34'sd1073741824;
        return v;
    endfunction

    function automatic q_t mul30(input q_t a, input q_t b);
        logic signed [67:0] p;
        p = (68'(a) * 68'(b)) + (68'sd1 <<< 29);
        return 34'(p >>> 30);
    endfunction

    function automatic logic signed [15:0] coef(input q_t v);
        q_t r;
        r = (v + (34'sd1 <<< (SH - 1))) >>> SH;
        if (r > (34'sd1 <<< COEF_FRAC_BITS)) r = 34'sd1 <<< COEF_FRAC_BITS;
        if (r < -(34'sd1 <<< COEF_FRAC_BITS)) r = -(34'sd1 <<< COEF_FRAC_BITS);
        if (r > 34'sd32767) r = 34'sd32767;
        if (r < -34'sd32768) r = -34'sd32768;
        return 16'(r);
    endfunction

    // final sin/cos
    q_t ct, st, cp, sp;
    always_comb
    begin
        q_t x, y;
        x = t_reg[NS].exact ? t_reg[NS].ex_x : clampq(t_reg[NS].x);
        y = t_reg[NS].exact ? t_reg[NS].ex_y : clampq(t_reg[NS].y);
        ct = t_reg[NS].neg ? -x : x;
        st = t_reg[NS].neg ? -y : y;
        x = p_reg[NS].exact ? p_reg[NS].ex_x : clampq(p_reg[NS].x);
        y = p_reg[NS].exact ? p_reg[NS].ex_y : clampq(p_reg[NS].y);
        cp = p_reg[NS].neg ? -x : x;
        sp = p_reg[NS].neg ? -y : y;
    end

    // product stages
    q_t ct_reg, st_reg, cp_reg, sp_reg;
    q_t fx_reg, fy_reg, fz_reg, ux_reg, uy_reg, usp_reg, rst_reg, rct_reg;
    logic dg_reg;
    logic signed [15:0] c_reg [0:8];
    logic dg3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS+2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[0] <= reduce(azimuth_angle);
            p_reg[0] <= reduce(polar_angle);
            d_reg[0] <= view_distance;
            for (int i = 0; i < NS; i++)
            begin
                t_reg[i+1] <= rot(t_reg[i], i);
                p_reg[i+1] <= rot(p_reg[i], i);
            end
            for (int i = 0; i < NS + 3; i++)
                d_reg[i+1] <= d_reg[i];
            ct_reg <= ct; st_reg <= st; cp_reg <= cp; sp_reg <= sp;
            // second stage: products and degenerate flag
            fx_reg  <= mul30(ct_reg, sp_reg);
            fy_reg  <= mul30(st_reg, sp_reg);
            fz_reg  <= cp_reg;
            dg_reg  <= (sp_reg == 0);
            ux_reg  <= mul30(cp_reg, ct_reg);
            uy_reg  <= mul30(cp_reg, st_reg);
            usp_reg <= sp_reg;
            rst_reg <= st_reg;
            rct_reg <= ct_reg;
            // third stage: signs and rounding
            if (dg_reg)
            begin
                for (int k = 0; k < 6; k++) c_reg[k] <= '0;
            end
            else if (usp_reg > 0)
            begin
                c_reg[0] <= coef(-rst_reg); c_reg[1] <= coef(rct_reg); c_reg[2] <= '0;
                c_reg[3] <= coef(-ux_reg); c_reg[4] <= coef(-uy_reg);
                c_reg[5] <= coef(usp_reg);
            end
            else
            begin
                c_reg[0] <= coef(rst_reg); c_reg[1] <= coef(-rct_reg); c_reg[2] <= '0;
                c_reg[3] <= coef(ux_reg); c_reg[4] <= coef(uy_reg);
                c_reg[5] <= coef(-usp_reg);
            end
            c_reg[6] <= coef(fx_reg); c_reg[7] <= coef(fy_reg); c_reg[8] <= coef(fz_reg);
            dg3_reg <= dg_reg;
        end
    end

    // row holder and sequencer
    logic signed [15:0] h_reg [0:8];
    logic [15:0] hd_reg;
    logic hdg_reg;
    always_comb
    begin
        hold_full_next = hold_full_reg;
        row_next = row_reg;
        if (hold_full_reg && !out_stall)
        begin
            row_next = row_reg + 2'd1;
            if (row_reg == ocvm_pkg::ROW_HOMOG) hold_full_next = 1'b0;
        end
        if (end_take)
        begin
            hold_full_next = 1'b1;
            row_next = ocvm_pkg::ROW_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_full_reg <= 1'b0;
            row_reg <= ocvm_pkg::ROW_RIGHT;
        end
        else
        begin
            hold_full_reg <= hold_full_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_take)
        begin
            for (int k = 0; k < 9; k++) h_reg[k] <= c_reg[k];
            hd_reg  <= d_reg[NS+3];
            hdg_reg <= dg3_reg;
        end
    end

    always_comb
    begin
        out_valid = hold_full_reg;
        row_index = row_reg;
        degenerate = hdg_reg;
        last_row = (row_reg == ocvm_pkg::ROW_HOMOG);
        case (row_reg)
            ocvm_pkg::ROW_RIGHT:
            begin
                coef_x = h_reg[0]; coef_y = h_reg[1]; coef_z = h_reg[2]; offset = '0;
            end
            ocvm_pkg::ROW_UP:
            begin
                coef_x = h_reg[3]; coef_y = h_reg[4]; coef_z = h_reg[5]; offset = '0;
            end
            ocvm_pkg::ROW_FWD:
            begin
                coef_x = h_reg[6]; coef_y = h_reg[7]; coef_z = h_reg[8];
                offset = -$signed({1'b0, hd_reg});
            end
            default:
            begin
                coef_x = '0; coef_y = '0; coef_z = '0; offset = 17'sd256;
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/ocvm_checker.sv */
// ocvm_checker: port-level assertions for orbit_camera_view_matrix
// depends on ocvm_pkg and is bound to the top level
`default_nettype none
module ocvm_checker (
    input wire clk,
    input wire rst_n,
    input wire in_valid,
    input wire in_stall,
    input wire out_valid,
    input wire out_stall,
    input wire [1:0] row_index,
    input wire signed [16:0] offset,
    input wire last_row
);
    // rows step in order within a matrix
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_row |=> out_valid &&
        row_index == $past(row_index) + 2'd1)
        else $error("row order broken");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last_row == (row_index == ocvm_pkg::ROW_HOMOG))
        else $error("last_row mismatch");
    a_homog: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_row |-> offset == 17'sd256)
        else $error("homogeneous offset wrong");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_index))
        else $error("stalled word changed");
    a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_stall))
        else $error("input stall unknown");
endmodule

bind orbit_camera_view_matrix ocvm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .row_index(row_index),
    .offset(offset), .last_row(last_row)
);
`default_nettype wire

/* tb/sv/orbit_camera_view_matrix_test.sv */
// orbit_camera_view_matrix_test: checks the orbit camera view matrix rows
// against a predictor built on a CORDIC sine/cosine; needs ocvm_pkg and the rtl
`default_nettype none
module orbit_camera_view_matrix_test;
    localparam int STAGES    = ocvm_pkg::CORDIC_STAGES_DEF;
    localparam int FRAC      = ocvm_pkg::COEF_FRAC_BITS_DEF;
    localparam int LATENCY   = STAGES + 4;
    localparam int N_RANDOM  = 340;
    localparam longint ONE30 = 64'sd1 << 30;

    typedef struct packed {
        ocvm_pkg::row_t     row;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic signed [16:0] off;
        logic               degen;
        logic               last;
    } row_word_t;

    typedef struct {
        logic signed [15:0] az;
        logic signed [15:0] pol;
        logic [15:0]        eye_dist;
        bit                 typed;   // expected rows given in the table
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        bit                 degen;
    } camera_case_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] azimuth_angle = '0;
    logic signed [15:0] polar_angle = '0;
    logic [15:0]        view_distance = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         row_index;
    logic signed [15:0] coef_x;
    logic signed [15:0] coef_y;
    logic signed [15:0] coef_z;
    logic signed [16:0] offset;
    logic               degenerate;
    logic               last_row;

    row_word_t expected_rows[$];
    int        mismatches = 0;
    bit        sending_done = 1'b0;
    bit        long_hold = 1'b0;

    orbit_camera_view_matrix dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .azimuth_angle(azimuth_angle), .polar_angle(polar_angle),
        .view_distance(view_distance),
        .out_valid(out_valid), .out_stall(out_stall),
        .row_index(row_index), .coef_x(coef_x), .coef_y(coef_y), .coef_z(coef_z),
        .offset(offset), .degenerate(degenerate), .last_row(last_row)
    );

    always #6 clk = ~clk;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return round_shift(a * b, 30);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // cosine and sine in Q30 of an angle in 1/64 degree
    task automatic cordic_sin_cos(input longint raw, output longint c, output longint s);
        longint a, x, y, z, nx;
        bit     flip;
        a = raw % ocvm_pkg::FULL_TURN;
        flip = 1'b0;
        if (a < 0)
            a += ocvm_pkg::FULL_TURN;
        if (a > ocvm_pkg::FULL_TURN - ocvm_pkg::QUARTER_TURN)
            a -= ocvm_pkg::FULL_TURN;
        else if (a > ocvm_pkg::QUARTER_TURN)
        begin
            a -= ocvm_pkg::HALF_TURN;
            flip = 1'b1;
        end
        if (a == 0)
        begin
            x = ONE30; y = 0;
        end
        else if (a == ocvm_pkg::QUARTER_TURN)
        begin
            x = 0; y = ONE30;
        end
        else if (a == -ocvm_pkg::QUARTER_TURN)
        begin
            x = 0; y = -ONE30;
        end
        else
        begin
            x = ocvm_pkg::CORDIC_START; y = 0; z = a * ocvm_pkg::UNIT_TO_RAD;
            for (int i = 0; i < STAGES && i < ocvm_pkg::MAX_STAGES; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - shr_floor(y, i); y = y + shr_floor(x, i);
                    z -= longint'(ocvm_pkg::atan_q30(i));
                end
                else
                begin
                    nx = x + shr_floor(y, i); y = y - shr_floor(x, i);
                    z += longint'(ocvm_pkg::atan_q30(i));
                end
                x = nx;
            end
            x = clip(x, -ONE30, ONE30);
            y = clip(y, -ONE30, ONE30);
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic signed [15:0] to_coef(longint q30);
        longint v;
        v = round_shift(q30, 30 - FRAC);
        v = clip(v, -(64'sd1 << FRAC), 64'sd1 << FRAC);
        v = clip(v, -32768, 32767);
        return v[15:0];
    endfunction

    function automatic row_word_t make_row(ocvm_pkg::row_t r, longint ax, longint ay,
                                           longint az, longint off, bit dg);
        row_word_t w;
        w.row = r;
        w.cx = to_coef(ax);
        w.cy = to_coef(ay);
        w.cz = to_coef(az);
        w.off = off[16:0];
        w.degen = dg;
        w.last = (r == ocvm_pkg::ROW_HOMOG);
        return w;
    endfunction

    task automatic predict_view_rows(input logic signed [15:0] az,
                                     input logic signed [15:0] pol,
                                     input logic [15:0] eye_dist);
        longint ct, st, cp, sp, sg;
        bit     dg;
        cordic_sin_cos(longint'(az), ct, st);
        cordic_sin_cos(longint'(pol), cp, sp);
        dg = (sp == 0);
        sg = sp > 0 ? 1 : -1;
        if (dg)
        begin
            expected_rows.push_back(make_row(ocvm_pkg::ROW_RIGHT, 0, 0, 0, 0, 1'b1));
            expected_rows.push_back(make_row(ocvm_pkg::ROW_UP, 0, 0, 0, 0, 1'b1));
        end
        else
        begin
            expected_rows.push_back(make_row(ocvm_pkg::ROW_RIGHT, -sg * st, sg * ct, 0, 0,
                                             1'b0));
            expected_rows.push_back(make_row(ocvm_pkg::ROW_UP, -sg * mul_q30(cp, ct),
                                             -sg * mul_q30(cp, st), sg * sp, 0, 1'b0));
        end
        expected_rows.push_back(make_row(ocvm_pkg::ROW_FWD, mul_q30(ct, sp),
                                         mul_q30(st, sp), cp, -longint'(eye_dist), dg));
        expected_rows.push_back(make_row(ocvm_pkg::ROW_HOMOG, 0, 0, 0, 256, dg));
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // directed cases: exact poles and axes are typed in, the rest predicted
    camera_case_t cases[$];
    function automatic camera_case_t mk(int az, int pol, int eye_dist, bit typed = 0,
                                        int fx = 0, int fy = 0, int fz = 0, bit dg = 0);
        camera_case_t c;
        c.az = 16'(az); c.pol = 16'(pol); c.eye_dist = 16'(eye_dist); c.typed = typed;
        c.fx = 16'(fx); c.fy = 16'(fy); c.fz = 16'(fz); c.degen = dg;
        return c;
    endfunction

    initial
    begin
        cases = '{
            mk(0, 0, 0, 1, 0, 0, 16384, 1),
            mk(5760, 0, 65535, 1, 0, 0, 16384, 1),
            mk(0, 11520, 256, 1, 0, 0, -16384, 1),
            mk(0, -11520, 1, 1, 0, 0, -16384, 1),
            mk(0, 23040, 100, 1, 0, 0, 16384, 1),
            mk(-23040, -23040, 65535, 1, 0, 0, 16384, 1),
            mk(0, 5760, 512),
            mk(5760, 5760, 512),
            mk(11520, -5760, 65535),
            mk(-5760, 17280, 0),
            mk(23040, 1, 1),
            mk(-23040, -1, 32768),
            mk(2880, 2880, 1000),
            mk(-2880, -2880, 32767),
            mk(17280, 8640, 4660),
            mk(-32768, 32767, 43981),
            mk(32767, -32768, 21845),
            mk(-1, 11519, 65534),
            mk(1, 11521, 2),
            mk(21555, 5759, 300)
        };
    end

    task automatic send_camera(input logic signed [15:0] az, input logic signed [15:0] pol,
                               input logic [15:0] eye_dist);
        in_valid <= 1'b1;
        azimuth_angle <= az;
        polar_angle <= pol;
        view_distance <= eye_dist;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender
    initial
    begin
        camera_case_t c;
        int gap;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (cases[k])
        begin
            c = cases[k];
            if (c.typed)
            begin
                expected_rows.push_back(make_row(ocvm_pkg::ROW_RIGHT, 0, 0, 0, 0, 1'b1));
                expected_rows.push_back(make_row(ocvm_pkg::ROW_UP, 0, 0, 0, 0, 1'b1));
                expected_rows.push_back('{ocvm_pkg::ROW_FWD, c.fx, c.fy, c.fz,
                                          -17'(c.eye_dist), 1'b1, 1'b0});
                expected_rows.push_back('{ocvm_pkg::ROW_HOMOG, 16'sd0, 16'sd0, 16'sd0,
                                          17'sd256, 1'b1, 1'b1});
            end
            else
                predict_view_rows(c.az, c.pol, c.eye_dist);
            send_camera(c.az, c.pol, c.eye_dist);
            idle_sender($urandom_range(0, 12) > 8 ? $urandom_range(0, 12) : 0);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            logic signed [15:0] az, pol;
            logic [15:0] eye_dist;
            if (n == 60)
                long_hold = 1'b1;
            if (n == 150)
            begin
                // drain completely before carrying on
                in_valid <= 1'b0;
                while (expected_rows.size() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 5))
                0: begin az = 16'($urandom); pol = 16'($urandom); end
                1:
                begin
                    az = 16'($urandom);
                    pol = 16'(int'($urandom_range(0, 8)) * 2880 - 11520);
                end
                default:
                begin
                    az = 16'(int'($urandom_range(0, 46080)) - 23040);
                    pol = 16'(int'($urandom_range(0, 46080)) - 23040);
                end
            endcase
            eye_dist = 16'($urandom);
            predict_view_rows(az, pol, eye_dist);
            send_camera(az, pol, eye_dist);
            gap = (n >= 200 && n < 260) ? 0 : $urandom_range(0, 12);
            idle_sender(gap);
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver stalls
    initial
    begin
        int w;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (120) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                w = $urandom_range(0, 12);
                if (w > 6)
                begin
                    out_stall <= 1'b1;
                    repeat (w) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // checker
    always @(posedge clk)
    begin
        row_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rows.size() == 0)
                report_mismatch("unexpected row", row_index, -1);
            else
            begin
                want = expected_rows.pop_front();
                if (row_index !== want.row) report_mismatch("row_index", row_index, want.row);
                if (coef_x !== want.cx) report_mismatch("coef_x", coef_x, want.cx);
                if (coef_y !== want.cy) report_mismatch("coef_y", coef_y, want.cy);
                if (coef_z !== want.cz) report_mismatch("coef_z", coef_z, want.cz);
                if (offset !== want.off) report_mismatch("offset", offset, want.off);
                if (degenerate !== want.degen)
                    report_mismatch("degenerate", degenerate, want.degen);
                if (last_row !== want.last) report_mismatch("last_row", last_row, want.last);
            end
        end
    end

    initial
    begin
        wait (sending_done);
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #1500000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
